[hw/rtl/idrr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idrr_pkg: shared definitions for the iso-tp fault report receiver
// Protocol bytes, phase and result codes, and the frame decision record.
// ---------------------------------------------------------------------------
package idrr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 90;
    localparam int unsigned MAX_FAULTS_DEF  = 16;

    localparam logic [28:0] RESET_REPLY_ID = 29'h18DAF140;

    // command codes on the mode field
    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_TX        = 2'd1;
    localparam logic [1:0] KIND_FAULT     = 2'd2;
    localparam logic [1:0] KIND_DONE_NONE = 2'd3;

    // session phases
    localparam logic [2:0] PH_SESSION  = 3'd0;
    localparam logic [2:0] PH_REPLY    = 3'd1;
    localparam logic [2:0] PH_SEGMENTS = 3'd2;
    localparam logic [2:0] PH_DONE     = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;
    localparam logic [2:0] PH_IDLE     = 3'd5;

    // iso-tp frame types
    localparam logic [3:0] PCI_SINGLE = 4'd0;
    localparam logic [3:0] PCI_FIRST  = 4'd1;
    localparam logic [3:0] PCI_CONSEC = 4'd2;

    // uds bytes
    localparam logic [7:0] SID_NEG_RSP    = 8'h7F;
    localparam logic [7:0] SID_SESS_RSP   = 8'h50;
    localparam logic [7:0] SESS_EXTENDED  = 8'h03;
    localparam logic [7:0] SID_DTC_RSP    = 8'h59;
    localparam logic [7:0] SUBFN_BY_MASK  = 8'h02;
    localparam logic [7:0] REQ_PCI        = 8'h03;
    localparam logic [7:0] SID_READ_DTC   = 8'h19;
    localparam logic [7:0] STATUS_MASK    = 8'hFF;
    localparam logic [7:0] FC_CONTINUE    = 8'h30;

    localparam logic [2:0] REQ_LENGTH     = 3'd4;
    localparam logic [2:0] FC_LENGTH      = 3'd3;
    localparam logic [2:0] FF_DATA_MAX    = 3'd6;
    localparam logic [2:0] SF_DATA_START  = 3'd1;
    localparam logic [2:0] FF_DATA_START  = 3'd2;
    localparam logic [2:0] CF_DATA_START  = 3'd1;
    localparam logic [3:0] DLC_MAX        = 4'd8;

    // dtc record layout in the reassembled payload
    localparam int unsigned REC_FIRST_OFF = 3;
    localparam int unsigned REC_STRIDE    = 4;
    localparam int unsigned REC_BYTES     = 3;

    typedef logic [7:0][7:0] frame_bytes_t;
    typedef logic [3:0][7:0] tx_bytes_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] kind;
        logic [2:0] tx_length;
        tx_bytes_t  tx;
        logic       report;
        logic [2:0] copy_src;
        logic [2:0] copy_cnt;
        logic [7:0] copy_dst;
        logic [7:0] received;
        logic [7:0] expected;
        logic [3:0] next_seq;
    } decision_t;

endpackage
`default_nettype wire

[hw/rtl/idrr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idrr_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module idrr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 90,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/idrr_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// idrr_decode: frame classifier
// Decides the next phase, the reply to send and the byte copy for one beat.
// ---------------------------------------------------------------------------
module idrr_decode #(
    parameter int unsigned MAX_PAYLOAD = idrr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic [1:0]              mode,
    input  wire logic [28:0]             can_id,
    input  wire logic [3:0]              dlc,
    input  wire idrr_pkg::frame_bytes_t  data,
    input  wire logic [28:0]             reply_id,
    input  wire logic [2:0]              phase_cur,
    input  wire logic [7:0]              received_cur,
    input  wire logic [7:0]              expected_cur,
    input  wire logic [3:0]              seq_cur,
    output idrr_pkg::decision_t          dec
);

    logic [3:0]  dlc_c;
    logic [3:0]  avail;
    logic [3:0]  pci;
    logic [3:0]  low;
    logic [11:0] total;
    logic [7:0]  total_cap;
    logic [7:0]  room;
    logic [2:0]  cf_cnt;

    always_comb
    begin
        dlc_c     = (dlc > idrr_pkg::DLC_MAX) ? idrr_pkg::DLC_MAX : dlc;
        avail     = (dlc_c == 4'd0) ? 4'd0 : dlc_c - 4'd1;
        pci       = data[0][7:4];
        low       = data[0][3:0];
        total     = {low, data[1]};
        total_cap = (total > 12'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : total[7:0];
        room      = (received_cur < expected_cur) ? expected_cur - received_cur : 8'd0;
        cf_cnt    = (room < {4'd0, avail}) ? room[2:0] : avail[2:0];

        dec           = '0;
        dec.phase     = phase_cur;
        dec.kind      = idrr_pkg::KIND_NONE;
        dec.received  = received_cur;
        dec.expected  = expected_cur;
        dec.next_seq  = seq_cur;

        case (mode)
            idrr_pkg::MODE_START:
            begin
                dec.phase = idrr_pkg::PH_SESSION;
            end
            idrr_pkg::MODE_STOP:
            begin
                dec.phase = idrr_pkg::PH_IDLE;
            end
            idrr_pkg::MODE_FRAME:
            begin
                if (can_id == reply_id && phase_cur != idrr_pkg::PH_IDLE)
                begin
                    if (dlc_c >= 4'd2 && data[1] == idrr_pkg::SID_NEG_RSP)
                    begin
                        dec.phase = idrr_pkg::PH_ERROR;
                    end
                    else if (phase_cur == idrr_pkg::PH_SESSION && dlc_c >= 4'd3 &&
                             data[1] == idrr_pkg::SID_SESS_RSP &&
                             data[2] == idrr_pkg::SESS_EXTENDED)
                    begin
                        dec.phase     = idrr_pkg::PH_REPLY;
                        dec.kind      = idrr_pkg::KIND_TX;
                        dec.tx_length = idrr_pkg::REQ_LENGTH;
                        dec.tx[0]     = idrr_pkg::REQ_PCI;
                        dec.tx[1]     = idrr_pkg::SID_READ_DTC;
                        dec.tx[2]     = idrr_pkg::SUBFN_BY_MASK;
                        dec.tx[3]     = idrr_pkg::STATUS_MASK;
                    end
                    else if (phase_cur == idrr_pkg::PH_REPLY && pci == idrr_pkg::PCI_SINGLE)
                    begin
                        // a single frame length never exceeds the smallest buffer
                        if (low >= 4'd3 && dlc_c >= 4'd4 &&
                            data[1] == idrr_pkg::SID_DTC_RSP &&
                            data[2] == idrr_pkg::SUBFN_BY_MASK)
                        begin
                            dec.copy_src = idrr_pkg::SF_DATA_START;
                            dec.copy_cnt = (low < avail) ? low[2:0] : avail[2:0];
                            dec.copy_dst = 8'd0;
                            dec.received = {4'd0, low};
                            dec.phase    = idrr_pkg::PH_DONE;
                            dec.report   = 1'b1;
                        end
                    end
                    else if (phase_cur == idrr_pkg::PH_REPLY && pci == idrr_pkg::PCI_FIRST)
                    begin
                        dec.expected  = total_cap;
                        dec.next_seq  = 4'd1;
                        dec.copy_src  = idrr_pkg::FF_DATA_START;
                        dec.copy_cnt  = (total_cap < {5'd0, idrr_pkg::FF_DATA_MAX}) ?
                                        total_cap[2:0] : idrr_pkg::FF_DATA_MAX;
                        dec.copy_dst  = 8'd0;
                        dec.received  = {5'd0, dec.copy_cnt};
                        dec.phase     = idrr_pkg::PH_SEGMENTS;
                        dec.kind      = idrr_pkg::KIND_TX;
                        dec.tx_length = idrr_pkg::FC_LENGTH;
                        dec.tx[0]     = idrr_pkg::FC_CONTINUE;
                    end
                    else if (phase_cur == idrr_pkg::PH_SEGMENTS &&
                             pci == idrr_pkg::PCI_CONSEC)
                    begin
                        if (low == seq_cur)
                        begin
                            dec.next_seq = seq_cur + 4'd1;
                            dec.copy_src = idrr_pkg::CF_DATA_START;
                            dec.copy_cnt = cf_cnt;
                            dec.copy_dst = received_cur;
                            dec.received = received_cur + {5'd0, cf_cnt};
                            if (dec.received >= expected_cur)
                            begin
                                dec.phase  = idrr_pkg::PH_DONE;
                                dec.report = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                dec.phase = phase_cur;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/isotp_dtc_report_receiver_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// isotp_dtc_report_receiver_top: iso-tp receiver for a uds fault report
// Sequence: an accepted frame is registered, decoded in the exec state, its
//   payload bytes are written one per cycle in the copy state, and a report
//   then checks for a complete record and reads each record's three bytes
//   before its result beat. A new frame is taken only in idle: stall stays
//   high until the last result beat is taken.
// Reset: phase idle, reply id at its default, buffer reads zero through
//   per-byte fill flags, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module isotp_dtc_report_receiver_top #(
    parameter int unsigned MAX_PAYLOAD = idrr_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned MAX_FAULTS  = idrr_pkg::MAX_FAULTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write_en,
    input  wire logic [28:0] cfg_write_data,

    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [28:0] can_id,
    input  wire logic [3:0]  dlc,
    input  wire logic [7:0]  byte0,
    input  wire logic [7:0]  byte1,
    input  wire logic [7:0]  byte2,
    input  wire logic [7:0]  byte3,
    input  wire logic [7:0]  byte4,
    input  wire logic [7:0]  byte5,
    input  wire logic [7:0]  byte6,
    input  wire logic [7:0]  byte7,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [2:0]       tx_length,
    output logic [7:0]       tx_first,
    output logic [7:0]       tx_second,
    output logic [7:0]       tx_third,
    output logic [7:0]       tx_fourth,
    output logic [23:0]      fault_code,
    output logic [5:0]       fault_index,
    output logic [2:0]       phase,
    output logic             last
);

    localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned OFF_W  = $clog2(MAX_PAYLOAD + 8);
    localparam int unsigned CMP_W  = (OFF_W > 8) ? OFF_W + 1 : 9;
    localparam int unsigned CNT_W  = $clog2(MAX_FAULTS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_COPY  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_RD1   = 8'b0001_0000,
        S_RD2   = 8'b0010_0000,
        S_RD3   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             received_reg, received_next;
    logic [7:0]             expected_reg, expected_next;
    logic [3:0]             seq_reg, seq_next;
    logic [28:0]            reply_id_reg;
    logic [MAX_PAYLOAD-1:0] filled_reg;
    logic                   rfill_reg;

    // captured frame
    logic [1:0]             mode_reg, mode_next;
    logic [28:0]            can_id_reg, can_id_next;
    logic [3:0]             dlc_reg, dlc_next;
    idrr_pkg::frame_bytes_t data_reg, data_next;

    // sequencer datapath
    logic [2:0]             copy_src_reg, copy_src_next;
    logic [2:0]             copy_cnt_reg, copy_cnt_next;
    logic [ADDR_W-1:0]      copy_dst_reg, copy_dst_next;
    logic                   report_reg, report_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // result
    logic [1:0]             kind_reg, kind_next;
    logic [2:0]             tx_len_reg, tx_len_next;
    idrr_pkg::tx_bytes_t    tx_reg, tx_next;
    logic [23:0]            code_reg, code_next;
    logic [5:0]             index_reg, index_next;
    logic                   last_reg, last_next;

    idrr_pkg::decision_t    dec;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [7:0]             mem_rdata;
    logic [7:0]             rd_byte;
    logic [OFF_W-1:0]       rd_step;
    logic [OFF_W-1:0]       addr_sum;
    logic                   more_now;
    logic                   more_after;

    function automatic logic rec_more(input logic [OFF_W-1:0] off,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [7:0]       recv);
        logic [CMP_W-1:0] o;
        begin
            o = CMP_W'(off);
            return ((o + CMP_W'(idrr_pkg::REC_STRIDE)) <= CMP_W'(recv)) &&
                   (cnt < CNT_W'(MAX_FAULTS)) &&
                   ((o + CMP_W'(idrr_pkg::REC_BYTES - 1)) < CMP_W'(MAX_PAYLOAD));
        end
    endfunction

    idrr_decode #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_decode (
        .mode         (mode_reg),
        .can_id       (can_id_reg),
        .dlc          (dlc_reg),
        .data         (data_reg),
        .reply_id     (reply_id_reg),
        .phase_cur    (phase_reg),
        .received_cur (received_reg),
        .expected_cur (expected_reg),
        .seq_cur      (seq_reg),
        .dec          (dec)
    );

    idrr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (copy_dst_reg),
        .wdata (data_reg[copy_src_reg]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared address adder: record offset plus byte step
    always_comb
    begin
        case (state_reg)
            S_RD1:   rd_step = OFF_W'(1);
            S_RD2:   rd_step = OFF_W'(2);
            default: rd_step = '0;
        endcase
        addr_sum   = off_reg + rd_step;
        mem_raddr  = ADDR_W'(addr_sum);
        mem_we     = (state_reg == S_COPY);
        rd_byte    = rfill_reg ? mem_rdata : 8'h00;
        more_now   = rec_more(off_reg, count_reg, received_reg);
        more_after = rec_more(off_reg + OFF_W'(idrr_pkg::REC_STRIDE),
                              count_reg + CNT_W'(1), received_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        received_next = received_reg;
        expected_next = expected_reg;
        seq_next      = seq_reg;
        mode_next     = mode_reg;
        can_id_next   = can_id_reg;
        dlc_next      = dlc_reg;
        data_next     = data_reg;
        copy_src_next = copy_src_reg;
        copy_cnt_next = copy_cnt_reg;
        copy_dst_next = copy_dst_reg;
        report_next   = report_reg;
        off_next      = off_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        tx_len_next   = tx_len_reg;
        tx_next       = tx_reg;
        code_next     = code_reg;
        index_next    = index_reg;
        last_next     = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    mode_next   = mode;
                    can_id_next = can_id;
                    dlc_next    = dlc;
                    data_next   = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                phase_next    = dec.phase;
                received_next = dec.received;
                expected_next = dec.expected;
                seq_next      = dec.next_seq;
                kind_next     = dec.kind;
                tx_len_next   = dec.tx_length;
                tx_next       = dec.tx;
                code_next     = '0;
                index_next    = '0;
                last_next     = 1'b1;
                copy_src_next = dec.copy_src;
                copy_cnt_next = dec.copy_cnt;
                copy_dst_next = ADDR_W'(dec.copy_dst);
                report_next   = dec.report;
                off_next      = OFF_W'(idrr_pkg::REC_FIRST_OFF);
                count_next    = '0;
                if (dec.copy_cnt != 3'd0)
                begin
                    state_next = S_COPY;
                end
                else if (dec.report)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_COPY:
            begin
                // one payload byte per cycle
                copy_src_next = copy_src_reg + 3'd1;
                copy_dst_next = copy_dst_reg + ADDR_W'(1);
                copy_cnt_next = copy_cnt_reg - 3'd1;
                if (copy_cnt_reg == 3'd1)
                begin
                    state_next = report_reg ? S_CHECK : S_OUT;
                end
            end
            S_CHECK:
            begin
                if (more_now)
                begin
                    state_next = S_RD1;
                end
                else
                begin
                    // report with no complete record
                    kind_next   = idrr_pkg::KIND_DONE_NONE;
                    tx_len_next = '0;
                    tx_next     = '0;
                    code_next   = '0;
                    index_next  = '0;
                    last_next   = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_RD1:
            begin
                code_next[23:16] = rd_byte;
                state_next       = S_RD2;
            end
            S_RD2:
            begin
                code_next[15:8] = rd_byte;
                state_next      = S_RD3;
            end
            S_RD3:
            begin
                code_next[7:0] = rd_byte;
                kind_next      = idrr_pkg::KIND_FAULT;
                tx_len_next    = '0;
                tx_next        = '0;
                index_next     = 6'(count_reg);
                off_next       = off_reg + OFF_W'(idrr_pkg::REC_STRIDE);
                count_next     = count_reg + CNT_W'(1);
                last_next      = !more_after;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = last_reg ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= idrr_pkg::PH_IDLE;
            received_reg <= '0;
            expected_reg <= '0;
            seq_reg      <= '0;
            reply_id_reg <= idrr_pkg::RESET_REPLY_ID;
            filled_reg   <= '0;
            rfill_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            received_reg <= received_next;
            expected_reg <= expected_next;
            seq_reg      <= seq_next;
            if (cfg_write_en)
            begin
                reply_id_reg <= cfg_write_data;
            end
            if (mem_we)
            begin
                filled_reg[copy_dst_reg] <= 1'b1;
            end
            // fill flag travels with the registered read data
            rfill_reg <= filled_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        can_id_reg   <= can_id_next;
        dlc_reg      <= dlc_next;
        data_reg     <= data_next;
        copy_src_reg <= copy_src_next;
        copy_cnt_reg <= copy_cnt_next;
        copy_dst_reg <= copy_dst_next;
        report_reg   <= report_next;
        off_reg      <= off_next;
        count_reg    <= count_next;
        kind_reg     <= kind_next;
        tx_len_reg   <= tx_len_next;
        tx_reg       <= tx_next;
        code_reg     <= code_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
    end

    assign frame_stall  = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign kind         = kind_reg;
    assign tx_length    = tx_len_reg;
    assign tx_first     = tx_reg[0];
    assign tx_second    = tx_reg[1];
    assign tx_third     = tx_reg[2];
    assign tx_fourth    = tx_reg[3];
    assign fault_code   = code_reg;
    assign fault_index  = index_reg;
    assign phase        = phase_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

[tb/tb_isotp_dtc_report_receiver_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_isotp_dtc_report_receiver_top: self-checking bench for the fault report receiver
// Opens with a scripted walk through the session, single frame, segmented
// reply, negative reply and ignored-frame cases, then runs randomized
// sessions under several reply identifiers. Every result beat is checked
// against its scripted beat or an in-bench model of the receiver, with random
// idling on both sides and one long hold on the result side.
// ---------------------------------------------------------------------------
module tb_isotp_dtc_report_receiver_top;
    import idrr_pkg::*;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam tx_bytes_t  REQ_TX       = {STATUS_MASK, SUBFN_BY_MASK, SID_READ_DTC, REQ_PCI};
    localparam tx_bytes_t  FC_TX        = {8'h00, 8'h00, 8'h00, FC_CONTINUE};
    localparam int         SHOWN_MAX    = 10;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         PHASE_ITEMS  = 50;
    localparam int         TIMEOUT_NS   = 10_000_000;

    typedef struct packed {
        logic [1:0]   mode;
        logic [28:0]  id;
        logic [3:0]   dlc;
        frame_bytes_t data;
    } can_frame_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  tx_length;
        tx_bytes_t   tx;
        logic [23:0] fault_code;
        logic [5:0]  fault_index;
        logic [2:0]  phase;
        logic        last;
    } report_beat_t;

    typedef struct packed {
        can_frame_t   f;
        bit           typed;
        report_beat_t want;
    } script_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write_en = 1'b0;
    logic [28:0]  cfg_write_data = '0;
    logic         frame_valid = 1'b0;
    logic         frame_stall;
    logic [1:0]   f_mode = MODE_FRAME;
    logic [28:0]  f_id = '0;
    logic [3:0]   f_dlc = '0;
    frame_bytes_t f_data = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    logic [1:0]   r_kind;
    logic [2:0]   r_tx_length;
    logic [7:0]   r_tx_first;
    logic [7:0]   r_tx_second;
    logic [7:0]   r_tx_third;
    logic [7:0]   r_tx_fourth;
    logic [23:0]  r_fault_code;
    logic [5:0]   r_fault_index;
    logic [2:0]   r_phase;
    logic         r_last;

    // receiver model state
    logic [28:0]  sim_reply_id;
    logic [2:0]   sim_phase;
    logic [7:0]   sim_buf [MAX_PAYLOAD_DEF];
    logic [7:0]   sim_expected;
    logic [7:0]   sim_received;
    logic [3:0]   sim_next_seq;

    report_beat_t expected_beats [$];
    report_beat_t decoded_beats [$];
    script_row_t  opening_rows [$];

    int errors = 0;
    int items = 0;
    bit offering = 1'b0;
    bit idle_on = 1'b1;
    bit want_long_hold = 1'b0;

    isotp_dtc_report_receiver_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .mode           (f_mode),
        .can_id         (f_id),
        .dlc            (f_dlc),
        .byte0          (f_data[0]),
        .byte1          (f_data[1]),
        .byte2          (f_data[2]),
        .byte3          (f_data[3]),
        .byte4          (f_data[4]),
        .byte5          (f_data[5]),
        .byte6          (f_data[6]),
        .byte7          (f_data[7]),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (r_kind),
        .tx_length      (r_tx_length),
        .tx_first       (r_tx_first),
        .tx_second      (r_tx_second),
        .tx_third       (r_tx_third),
        .tx_fourth      (r_tx_fourth),
        .fault_code     (r_fault_code),
        .fault_index    (r_fault_index),
        .phase          (r_phase),
        .last           (r_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit rare();
        return $urandom_range(0, 9) == 0;
    endfunction

    function automatic logic [3:0] pick_dlc(input int lo);
        if ($urandom_range(0, 9) < 7)
        begin
            return DLC_MAX;
        end
        return 4'($urandom_range(lo, 15));
    endfunction

    // bytes given in wire order, byte0 in the top eight bits
    function automatic can_frame_t rx(input logic [28:0] id, input logic [3:0] n,
                                      input logic [63:0] wire_order);
        can_frame_t f;
        int i;
        f.mode = MODE_FRAME;
        f.id = id;
        f.dlc = n;
        for (i = 0; i < 8; i++)
        begin
            f.data[i] = wire_order[63 - 8 * i -: 8];
        end
        return f;
    endfunction

    function automatic can_frame_t cmd(input logic [1:0] m);
        can_frame_t f;
        f.mode = m;
        f.id = 29'($urandom);
        f.dlc = 4'($urandom);
        f.data = {$urandom, $urandom};
        return f;
    endfunction

    function automatic can_frame_t rnd_frame();
        can_frame_t f;
        f = cmd(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0)
        begin
            f.id = sim_reply_id;
        end
        return f;
    endfunction

    function automatic can_frame_t on_reply(input logic [3:0] n, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2);
        can_frame_t f;
        f = cmd(MODE_FRAME);
        f.id = sim_reply_id;
        f.dlc = n;
        f.data[0] = b0;
        f.data[1] = b1;
        f.data[2] = b2;
        return f;
    endfunction

    function automatic report_beat_t plain_beat(input logic [1:0] k, input logic [2:0] len,
                                                input tx_bytes_t tx, input logic [2:0] ph);
        report_beat_t b;
        b = '0;
        b.kind = k;
        b.tx_length = len;
        b.tx = tx;
        b.phase = ph;
        b.last = 1'b1;
        return b;
    endfunction

    task automatic add_row(input can_frame_t f, input bit typed, input report_beat_t want);
        script_row_t r;
        r.f = f;
        r.typed = typed;
        r.want = want;
        opening_rows.push_back(r);
    endtask

    task automatic push_beat(input logic [1:0] k, input logic [2:0] len, input tx_bytes_t tx,
                             input logic [23:0] code, input logic [5:0] idx);
        report_beat_t b;
        b.kind = k;
        b.tx_length = len;
        b.tx = tx;
        b.fault_code = code;
        b.fault_index = idx;
        b.phase = sim_phase;
        b.last = 1'b0;
        decoded_beats.push_back(b);
    endtask

    // one beat per 4-byte record from offset 3, or a done-with-none beat
    task automatic build_report();
        int off;
        int cnt;
        off = REC_FIRST_OFF;
        cnt = 0;
        while (off + REC_STRIDE <= sim_received && cnt < MAX_FAULTS_DEF &&
               off + 2 < MAX_PAYLOAD_DEF)
        begin
            push_beat(KIND_FAULT, 3'd0, '0,
                      {sim_buf[off], sim_buf[off + 1], sim_buf[off + 2]}, 6'(cnt));
            cnt++;
            off += REC_STRIDE;
        end
        if (cnt == 0)
        begin
            push_beat(KIND_DONE_NONE, 3'd0, '0, 24'd0, 6'd0);
        end
    endtask

    task automatic decode_frame(input can_frame_t f);
        logic [3:0] n;
        int plen;
        int total;
        int take;
        int i;
        decoded_beats.delete();
        n = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
        if (f.mode == MODE_START)
        begin
            sim_phase = PH_SESSION;
        end
        else if (f.mode == MODE_STOP)
        begin
            sim_phase = PH_IDLE;
        end
        else if (f.mode == MODE_FRAME && f.id == sim_reply_id && sim_phase != PH_IDLE)
        begin
            if (n >= 2 && f.data[1] == SID_NEG_RSP)
            begin
                sim_phase = PH_ERROR;
            end
            else if (sim_phase == PH_SESSION && n >= 3 && f.data[1] == SID_SESS_RSP &&
                     f.data[2] == SESS_EXTENDED)
            begin
                sim_phase = PH_REPLY;
                push_beat(KIND_TX, REQ_LENGTH, REQ_TX, 24'd0, 6'd0);
            end
            else if (sim_phase == PH_REPLY && f.data[0][7:4] == PCI_SINGLE)
            begin
                plen = f.data[0][3:0];
                if (plen >= 3 && n >= 4 && f.data[1] == SID_DTC_RSP &&
                    f.data[2] == SUBFN_BY_MASK)
                begin
                    // declared length wins even when fewer bytes came along
                    for (i = 0; i < plen && i + 1 < n; i++)
                    begin
                        sim_buf[i] = f.data[i + 1];
                    end
                    sim_received = 8'(plen);
                    sim_phase = PH_DONE;
                    build_report();
                end
            end
            else if (sim_phase == PH_REPLY && f.data[0][7:4] == PCI_FIRST)
            begin
                total = {f.data[0][3:0], f.data[1]};
                if (total > MAX_PAYLOAD_DEF)
                begin
                    total = MAX_PAYLOAD_DEF;
                end
                sim_expected = 8'(total);
                sim_next_seq = 4'd1;
                take = (total < FF_DATA_MAX) ? total : FF_DATA_MAX;
                // first frame copies its bytes whatever the dlc says
                for (i = 0; i < take; i++)
                begin
                    sim_buf[i] = f.data[i + 2];
                end
                sim_received = 8'(take);
                sim_phase = PH_SEGMENTS;
                push_beat(KIND_TX, FC_LENGTH, FC_TX, 24'd0, 6'd0);
            end
            else if (sim_phase == PH_SEGMENTS && f.data[0][7:4] == PCI_CONSEC &&
                     f.data[0][3:0] == sim_next_seq)
            begin
                sim_next_seq = sim_next_seq + 4'd1;
                for (i = 1; i < n && sim_received < sim_expected &&
                            sim_received < MAX_PAYLOAD_DEF; i++)
                begin
                    sim_buf[sim_received] = f.data[i];
                    sim_received = sim_received + 8'd1;
                end
                if (sim_received >= sim_expected)
                begin
                    sim_phase = PH_DONE;
                    build_report();
                end
            end
        end
        if (decoded_beats.size() == 0)
        begin
            push_beat(KIND_NONE, 3'd0, '0, 24'd0, 6'd0);
        end
        decoded_beats[decoded_beats.size() - 1].last = 1'b1;
    endtask

    task automatic release_frame();
        if (offering)
        begin
            frame_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_frame(input can_frame_t f, input bit typed = 1'b0,
                              input report_beat_t want = '0);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            release_frame();
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        offering = 1'b1;
        f_mode <= f.mode;
        f_id <= f.id;
        f_dlc <= f.dlc;
        f_data <= f.data;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        decode_frame(f);
        if (typed)
        begin
            expected_beats.push_back(want);
        end
        else
        begin
            foreach (decoded_beats[k])
            begin
                expected_beats.push_back(decoded_beats[k]);
            end
        end
        items++;
    endtask

    task automatic set_reply_id(input logic [28:0] v);
        release_frame();
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sim_reply_id = v;
    endtask

    // start, accept, then a single frame, a segmented reply or a refusal
    task automatic random_session();
        logic [11:0] total;
        logic [3:0]  seq;
        logic [3:0]  plen;
        int          cfs;
        int          r;
        send_frame(cmd(MODE_START));
        if (rare())
        begin
            send_frame(rnd_frame());
        end
        send_frame(on_reply(pick_dlc(3), 8'($urandom),
                            rare() ? 8'($urandom) : SID_SESS_RSP,
                            rare() ? 8'($urandom) : SESS_EXTENDED));
        if (sim_phase != PH_REPLY)
        begin
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            send_frame(on_reply(pick_dlc(2), 8'($urandom), SID_NEG_RSP, 8'($urandom)));
        end
        else if (r < 45)
        begin
            plen = rare() ? 4'($urandom) : 4'($urandom_range(3, 15));
            send_frame(on_reply(pick_dlc(rare() ? 0 : 4), {PCI_SINGLE, plen},
                                rare() ? 8'($urandom) : SID_DTC_RSP,
                                rare() ? 8'($urandom) : SUBFN_BY_MASK));
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                total = 12'($urandom_range(0, 40));
            end
            else if (r < 9)
            begin
                total = 12'($urandom_range(41, 95));
            end
            else
            begin
                total = 12'($urandom);
            end
            send_frame(on_reply(pick_dlc(0), {PCI_FIRST, total[11:8]}, total[7:0],
                                SID_DTC_RSP));
            cfs = 0;
            while (sim_phase == PH_SEGMENTS && cfs < 40)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    send_frame(rnd_frame());
                end
                else
                begin
                    seq = (r < 12) ? 4'($urandom) : sim_next_seq;
                    send_frame(on_reply(pick_dlc(0), {PCI_CONSEC, seq}, 8'($urandom),
                                        8'($urandom)));
                end
                cfs++;
            end
        end
        if ($urandom_range(0, 29) == 0)
        begin
            send_frame(cmd(MODE_STOP));
        end
    endtask

    // result side pacing, long hold counted here
    initial
    begin : result_pacing
        int n;
        forever
        begin
            @(posedge clk);
            if (want_long_hold)
            begin
                want_long_hold = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 5);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input report_beat_t want,
                                 input report_beat_t got);
        errors++;
        if (errors <= SHOWN_MAX)
        begin
            $display("%0t %s: exp kind=%0d len=%0d tx=%h code=%h idx=%0d ph=%0d last=%b",
                     $realtime, what, want.kind, want.tx_length, want.tx, want.fault_code,
                     want.fault_index, want.phase, want.last);
            $display("%0t %s: got kind=%0d len=%0d tx=%h code=%h idx=%0d ph=%0d last=%b",
                     $realtime, what, got.kind, got.tx_length, got.tx, got.fault_code,
                     got.fault_index, got.phase, got.last);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        report_beat_t got;
        report_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got.kind = r_kind;
            got.tx_length = r_tx_length;
            got.tx = {r_tx_fourth, r_tx_third, r_tx_second, r_tx_first};
            got.fault_code = r_fault_code;
            got.fault_index = r_fault_index;
            got.phase = r_phase;
            got.last = r_last;
            if (expected_beats.size() == 0)
            begin
                note_mismatch("unexpected beat", '0, got);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind || got.tx_length !== want.tx_length ||
                    got.tx !== want.tx || got.fault_code !== want.fault_code ||
                    got.fault_index !== want.fault_index || got.phase !== want.phase ||
                    got.last !== want.last)
                begin
                    note_mismatch("beat mismatch", want, got);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [28:0] reply_ids [4];
        logic [28:0] rid;
        int target;
        int p;
        int i;
        sim_reply_id = RESET_REPLY_ID;
        sim_phase = PH_IDLE;
        sim_expected = '0;
        sim_received = '0;
        sim_next_seq = '0;
        for (i = 0; i < MAX_PAYLOAD_DEF; i++)
        begin
            sim_buf[i] = '0;
        end
        rid = RESET_REPLY_ID;

        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_IDLE));
        add_row(cmd(MODE_SPARE), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_IDLE));
        add_row(cmd(MODE_START), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(29'h1FFF_FFFF, 4'd8, 64'h02_50_03_FF_FF_FF_FF_FF), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        // one byte only: neither a refusal nor an accept
        add_row(rx(rid, 4'd1, 64'h02_7F_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_TX, REQ_LENGTH, REQ_TX, PH_REPLY));
        add_row(rx(rid, 4'd8, 64'h07_59_02_FF_12_34_56_09), 1'b0, '0);
        add_row(cmd(MODE_START), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(rid, 4'hF, 64'h02_50_03_FF_FF_FF_FF_FF), 1'b1,
                plain_beat(KIND_TX, REQ_LENGTH, REQ_TX, PH_REPLY));
        // overlong single frame picks up stale bytes
        add_row(rx(rid, 4'd4, 64'h0F_59_02_AA_FF_FF_FF_FF), 1'b0, '0);
        add_row(cmd(MODE_START), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_TX, REQ_LENGTH, REQ_TX, PH_REPLY));
        add_row(rx(rid, 4'd4, 64'h03_7F_19_31_00_00_00_00), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_ERROR));
        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_ERROR));
        add_row(cmd(MODE_START), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_TX, REQ_LENGTH, REQ_TX, PH_REPLY));
        add_row(rx(rid, 4'd8, 64'h10_0E_59_02_FF_A1_B2_C3), 1'b1,
                plain_beat(KIND_TX, FC_LENGTH, FC_TX, PH_SEGMENTS));
        add_row(rx(rid, 4'd8, 64'h22_11_22_33_44_55_66_77), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_SEGMENTS));
        add_row(rx(rid, 4'd8, 64'h21_00_D4_E5_F6_80_7E_01), 1'b0, '0);
        add_row(rx(rid, 4'd2, 64'h22_5A_FF_FF_FF_FF_FF_FF), 1'b0, '0);
        add_row(rx(rid, 4'd2, 64'h01_7F_00_00_00_00_00_00), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_ERROR));
        add_row(cmd(MODE_START), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_SESSION));
        add_row(rx(rid, 4'd3, 64'h02_50_03_00_00_00_00_00), 1'b1,
                plain_beat(KIND_TX, REQ_LENGTH, REQ_TX, PH_REPLY));
        // short first frame, the next segment closes it with no records
        add_row(rx(rid, 4'd2, 64'h10_04_59_02_77_88_99_AA), 1'b1,
                plain_beat(KIND_TX, FC_LENGTH, FC_TX, PH_SEGMENTS));
        add_row(rx(rid, 4'd1, 64'h21_FF_FF_FF_FF_FF_FF_FF), 1'b1,
                plain_beat(KIND_DONE_NONE, 3'd0, '0, PH_DONE));
        add_row(cmd(MODE_STOP), 1'b1, plain_beat(KIND_NONE, 3'd0, '0, PH_IDLE));
        add_row(rx(29'h0, 4'd0, 64'hFF_FF_FF_FF_FF_FF_FF_FF), 1'b1,
                plain_beat(KIND_NONE, 3'd0, '0, PH_IDLE));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[k])
        begin
            send_frame(opening_rows[k].f, opening_rows[k].typed, opening_rows[k].want);
        end

        reply_ids[0] = 29'h1FFF_FFFF;
        reply_ids[1] = 29'h0;
        reply_ids[2] = 29'($urandom);
        reply_ids[3] = RESET_REPLY_ID;
        for (p = 0; p < 4; p++)
        begin
            set_reply_id(reply_ids[p]);
            if (p == 1)
            begin
                want_long_hold = 1'b1;
            end
            if (p == 3)
            begin
                idle_on = 1'b0;
            end
            target = items + PHASE_ITEMS;
            while (items < target)
            begin
                random_session();
            end
        end

        release_frame();
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
